// File: sv/wave_equation_stencil_step_assert.svh
// Assertion macros used by the wave stencil RTL.
`ifndef WAVE_EQUATION_STENCIL_STEP_ASSERT_SVH
`define WAVE_EQUATION_STENCIL_STEP_ASSERT_SVH

// Check that a condition holds at every active clock edge.
`define WES_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("wave stencil check failed");

// Check that a trigger implies a consequence in the same cycle.
`define WES_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wave stencil check failed");

`endif

// File: sv/wes_pkg.sv
// ---------------------------------------------------------------------------
// wes_pkg
// Shared types and constants of the 2-D wave equation stencil block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wes_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COEFFICIENT = 2'd2;

    localparam logic [10:0] GRID_WIDTH_RESET  = 11'd64;
    localparam logic [12:0] GRID_HEIGHT_RESET = 13'd64;

    // Product of c2*coef (Q24.40) and the Laplacian is scaled down by 2^40
    localparam int FRAC_SHIFT = 40;

    // Front end sequencer
    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_WORK,
        F_PUSH
    } front_state_t;

    // Back end sequencer
    typedef enum logic [2:0] {
        B_IDLE,
        B_COEF,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_FIN
    } back_state_t;

    // Arithmetic part of one queued result job
    typedef struct packed {
        logic signed [35:0] lap;   // 5-point Laplacian, Q20.16
        logic signed [33:0] base;  // 2p - p_old, or the copied value
        logic [31:0]        vel;   // squared velocity, Q24.8
    } arith_t;

endpackage

`default_nettype wire

// File: sv/wes_queue.sv
// ---------------------------------------------------------------------------
// wes_queue
// Short first-in first-out queue of result jobs between front and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wave_equation_stencil_step_assert.svh"

module wes_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty
);

    localparam int DEPTH = 4;

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [1:0]        wr_ptr_reg;
    logic [1:0]        rd_ptr_reg;
    logic [2:0]        count_reg;

    assign full     = (count_reg == 3'(DEPTH));
    assign empty    = (count_reg == 3'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Store pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 3'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

    `WES_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full))
    `WES_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty))
    `WES_ASSERT_IMPLIES(a_count_ptrs, clk, rst_n, count_reg == 3'd0, wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

// File: sv/wes_front.sv
// ---------------------------------------------------------------------------
// wes_front
// Accepts grid points, runs the line buffers and window, and queues the
// result jobs each point causes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wes_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW         = 10,
    parameter int RW         = 12,
    parameter int JOB_W      = CW + RW + 1 + $bits(wes_pkg::arith_t)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [31:0]       pressure_now,
    input  wire logic [31:0]       pressure_before,
    input  wire logic [31:0]       velocity_squared,
    input  wire logic              restart,
    input  wire logic [CW:0]       w_eff,
    input  wire logic [RW:0]       h_eff,
    output logic                   push,
    output logic [JOB_W-1:0]       push_data,
    input  wire logic              full
);

    localparam int ARITH_W = $bits(wes_pkg::arith_t);
    localparam int SLOT_W  = CW + RW + ARITH_W;

    wes_pkg::front_state_t state_reg, state_next;

    logic [127:0]        mem [MAX_WIDTH];
    logic [127:0]        rd_reg;
    logic [CW-1:0]       x_reg;
    logic [RW-1:0]       z_reg;
    logic [31:0]         pn_reg, pb_reg, vel_reg;
    logic [31:0]         win_above_1_reg, win_above_2_reg, win_two_1_reg;
    logic [31:0]         win_old_1_reg, win_vel_1_reg, left_reg;
    logic [SLOT_W-1:0]   slot_reg [3];
    logic [SLOT_W-1:0]   slot_next [3];
    logic [1:0]          n_reg, n_next;
    logic [1:0]          idx_reg;

    logic [CW:0]         wm1_full;
    logic [RW:0]         hm1_full;
    logic [CW-1:0]       wm1;
    logic [RW-1:0]       hm1;
    logic [31:0]         rd_a, rd_t, rd_o, rd_v;
    logic signed [35:0]  lap;
    logic signed [33:0]  base;
    wes_pkg::arith_t     ar0, ar1, ar2;
    logic                e0, e1, e2, interior;

    assign wm1_full = w_eff - 1'b1;
    assign hm1_full = h_eff - 1'b1;
    assign wm1      = wm1_full[CW-1:0];
    assign hm1      = hm1_full[RW-1:0];

    assign rd_a = rd_reg[127:96];
    assign rd_t = rd_reg[95:64];
    assign rd_o = rd_reg[63:32];
    assign rd_v = rd_reg[31:0];

    // Line buffer: read in F_READ, write back in F_WORK
    always_ff @(posedge clk)
    begin
        if (state_reg == wes_pkg::F_READ)
        begin
            rd_reg <= mem[x_reg];
        end
        if (state_reg == wes_pkg::F_WORK)
        begin
            mem[x_reg] <= {pn_reg, rd_a, pb_reg, vel_reg};
        end
    end

    // Stencil operands: center is p(x-1,z-1), west p(x-2,z-1), east p(x,z-1)
    always_comb
    begin
        lap = 36'(signed'(win_above_2_reg)) + 36'(signed'(rd_a))
            + 36'(signed'(win_two_1_reg)) + 36'(signed'(left_reg))
            - (36'(signed'(win_above_1_reg)) <<< 2);
        base = (34'(signed'(win_above_1_reg)) <<< 1) - 34'(signed'(win_old_1_reg));
    end

    // Classify the results this point causes
    always_comb
    begin
        e0       = (x_reg != '0) && (z_reg != '0);
        e1       = (x_reg == wm1) && (z_reg != '0);
        e2       = (z_reg == hm1);
        interior = (x_reg >= CW'(2)) && (z_reg >= RW'(2));

        ar0.vel  = win_vel_1_reg;
        ar0.lap  = interior ? lap : '0;
        ar0.base = interior ? base : 34'(signed'(win_above_1_reg));
        ar1.vel  = '0;
        ar1.lap  = '0;
        ar1.base = 34'(signed'(rd_a));
        ar2.vel  = '0;
        ar2.lap  = '0;
        ar2.base = 34'(signed'(pn_reg));

        n_next = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i] = '0;
        end
        if (e0)
        begin
            slot_next[n_next] = {x_reg - CW'(1), z_reg - RW'(1), ar0};
            n_next = n_next + 2'd1;
        end
        if (e1)
        begin
            slot_next[n_next] = {x_reg, z_reg - RW'(1), ar1};
            n_next = n_next + 2'd1;
        end
        if (e2)
        begin
            slot_next[n_next] = {x_reg, z_reg, ar2};
            n_next = n_next + 2'd1;
        end
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wes_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            wes_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = wes_pkg::F_READ;
                end
            end
            wes_pkg::F_READ:
            begin
                state_next = wes_pkg::F_WORK;
            end
            wes_pkg::F_WORK:
            begin
                state_next = (n_next == 2'd0) ? wes_pkg::F_IDLE : wes_pkg::F_PUSH;
            end
            wes_pkg::F_PUSH:
            begin
                push = !full;
                if (!full && (idx_reg == n_reg - 2'd1))
                begin
                    state_next = wes_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = wes_pkg::F_IDLE;
            end
        endcase
    end

    assign push_data = {slot_reg[idx_reg][SLOT_W-1:ARITH_W], idx_reg == n_reg - 2'd1,
                        slot_reg[idx_reg][ARITH_W-1:0]};

    // Latch payload and queued slots
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pn_reg  <= pressure_now;
            pb_reg  <= pressure_before;
            vel_reg <= velocity_squared;
        end
        if (state_reg == wes_pkg::F_WORK)
        begin
            for (int i = 0; i < 3; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // Advance window, raster position and push index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg           <= '0;
            z_reg           <= '0;
            n_reg           <= 2'd0;
            idx_reg         <= 2'd0;
            left_reg        <= '0;
            win_above_1_reg <= '0;
            win_above_2_reg <= '0;
            win_two_1_reg   <= '0;
            win_old_1_reg   <= '0;
            win_vel_1_reg   <= '0;
        end
        else if (restart)
        begin
            x_reg <= '0;
            z_reg <= '0;
        end
        else if (state_reg == wes_pkg::F_WORK)
        begin
            n_reg           <= n_next;
            idx_reg         <= 2'd0;
            win_above_2_reg <= win_above_1_reg;
            win_above_1_reg <= rd_a;
            win_two_1_reg   <= rd_t;
            win_old_1_reg   <= rd_o;
            win_vel_1_reg   <= rd_v;
            left_reg        <= pn_reg;
            if (x_reg == wm1)
            begin
                x_reg <= '0;
                z_reg <= (z_reg == hm1) ? '0 : z_reg + RW'(1);
            end
            else
            begin
                x_reg <= x_reg + CW'(1);
            end
        end
        else if (push)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: sv/wes_back.sv
// ---------------------------------------------------------------------------
// wes_back
// Carries out queued result jobs: scaled Laplacian term, rounding,
// saturation, and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wes_back #(
    parameter int CW    = 10,
    parameter int RW    = 12,
    parameter int JOB_W = CW + RW + 1 + $bits(wes_pkg::arith_t)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               empty,
    output logic                    pop,
    input  wire logic [JOB_W-1:0]   pop_data,
    input  wire logic [31:0]        coef,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [CW-1:0]           out_column,
    output logic [RW-1:0]           out_row,
    output logic signed [31:0]      pressure_next,
    output logic                    run_last
);

    localparam int ARITH_W = $bits(wes_pkg::arith_t);
    localparam logic [40:0] CAP = 41'(1) << wes_pkg::FRAC_SHIFT;
    localparam logic [98:0] HALF = 99'(1) << (wes_pkg::FRAC_SHIFT - 1);

    wes_pkg::back_state_t state_reg, state_next;
    wes_pkg::arith_t      job;

    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic                last_reg;
    logic [34:0]         mag_reg;
    logic                neg_reg;
    logic signed [33:0]  base_reg;
    logic [31:0]         vel_reg;
    logic [63:0]         k_reg;
    logic [66:0]         p0_reg, p1_reg;
    logic [98:0]         prod_reg;
    logic                out_valid_reg;
    logic [CW-1:0]       out_column_reg;
    logic [RW-1:0]       out_row_reg;
    logic signed [31:0]  pressure_next_reg;
    logic                run_last_reg;

    logic [35:0]         lap_abs;
    logic [98:0]         rounded;
    logic [58:0]         tm;
    logic [40:0]         term_mag;
    logic signed [42:0]  term, total;
    logic signed [31:0]  sat;
    logic                load_out;

    assign job     = pop_data[ARITH_W-1:0];
    assign lap_abs = job.lap[35] ? 36'(-job.lap) : 36'(job.lap);

    // Round, clamp and saturate
    always_comb
    begin
        rounded  = prod_reg + HALF;
        tm       = rounded[98:wes_pkg::FRAC_SHIFT];
        term_mag = (tm > 59'(CAP)) ? CAP : tm[40:0];
        term     = neg_reg ? -43'(term_mag) : 43'(term_mag);
        total    = 43'(base_reg) + term;
        priority if (total > 43'sh0_7FFF_FFFF)
        begin
            sat = 32'sh7FFF_FFFF;
        end
        else if (total < -43'sh0_8000_0000)
        begin
            sat = -32'sh8000_0000;
        end
        else
        begin
            sat = total[31:0];
        end
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wes_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and queue/output strobes
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            wes_pkg::B_IDLE:
            begin
                pop = !empty;
                if (!empty)
                begin
                    state_next = wes_pkg::B_COEF;
                end
            end
            wes_pkg::B_COEF:   state_next = wes_pkg::B_MUL_LO;
            wes_pkg::B_MUL_LO: state_next = wes_pkg::B_MUL_HI;
            wes_pkg::B_MUL_HI: state_next = wes_pkg::B_SUM;
            wes_pkg::B_SUM:    state_next = wes_pkg::B_FIN;
            wes_pkg::B_FIN:
            begin
                load_out = !out_valid_reg || out_ready;
                if (load_out)
                begin
                    state_next = wes_pkg::B_IDLE;
                end
            end
            default:           state_next = wes_pkg::B_IDLE;
        endcase
    end

    // Multiply datapath: one 32-bit-class multiply per cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg  <= pop_data[JOB_W-1 -: CW];
            row_reg  <= pop_data[JOB_W-CW-1 -: RW];
            last_reg <= pop_data[ARITH_W];
            mag_reg  <= lap_abs[34:0];
            neg_reg  <= job.lap[35];
            base_reg <= job.base;
            vel_reg  <= job.vel;
        end
        if (state_reg == wes_pkg::B_COEF)
        begin
            k_reg <= 64'(vel_reg) * 64'(coef);
        end
        if (state_reg == wes_pkg::B_MUL_LO)
        begin
            p0_reg <= 67'(k_reg[31:0]) * 67'(mag_reg);
        end
        if (state_reg == wes_pkg::B_MUL_HI)
        begin
            p1_reg <= 67'(k_reg[63:32]) * 67'(mag_reg);
        end
        if (state_reg == wes_pkg::B_SUM)
        begin
            prod_reg <= 99'(p0_reg) + (99'(p1_reg) << 32);
        end
        if (load_out)
        begin
            out_column_reg    <= col_reg;
            out_row_reg       <= row_reg;
            pressure_next_reg <= sat;
            run_last_reg      <= last_reg;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_column    = out_column_reg;
    assign out_row       = out_row_reg;
    assign pressure_next = pressure_next_reg;
    assign run_last      = run_last_reg;

endmodule

`default_nettype wire

// File: sv/wave_equation_stencil_step.sv
// ---------------------------------------------------------------------------
// wave_equation_stencil_step
// One explicit time step of the 2-D acoustic wave equation, 5-point stencil.
// ---------------------------------------------------------------------------
// Grid points enter on the in channel (valid/ready) in raster order with
// pressure_now, pressure_before and velocity_squared. Results leave on the
// out channel (valid/ready), tagged with out_column/out_row; run_last marks
// the last result an input causes (zero to three results per input).
// The cfg channel writes grid_width (0), grid_height (1) and the Q0.32
// time/space coefficient (2); a geometry write restarts the frame at (0,0).
// The front end takes a point in F_IDLE, passes F_READ and F_WORK, then
// pushes each queued result in F_PUSH while the queue has room. The back
// end pops a job, then forms vel*coef, two partial products of the 64 x 35
// bit scaling multiply, the product sum, then rounding and saturation into
// the output register, and pops no new job until that register is loaded.
// A 4-entry job queue separates the two.
// Reset restores 64 x 64 geometry, a zero coefficient and an empty pipeline;
// line buffers are not cleared. A stalled receiver holds the output register,
// then fills the queue, then stops input acceptance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wave_equation_stencil_step #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [31:0]                    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [31:0]                    pressure_now,
    input  wire logic [31:0]                    pressure_before,
    input  wire logic [31:0]                    velocity_squared,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]        out_column,
    output logic [$clog2(MAX_HEIGHT)-1:0]       out_row,
    output logic signed [31:0]                  pressure_next,
    output logic                                run_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int JOB_W = CW + RW + 1 + $bits(wes_pkg::arith_t);

    logic [10:0]       grid_width_reg;
    logic [12:0]       grid_height_reg;
    logic [31:0]       coef_reg;
    logic [CW:0]       w_eff;
    logic [RW:0]       h_eff;
    logic              cfg_write, restart;
    logic              push, pop, full, empty;
    logic [JOB_W-1:0]  push_data, pop_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && ((cfg_index == wes_pkg::REG_GRID_WIDTH) ||
                                     (cfg_index == wes_pkg::REG_GRID_HEIGHT));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= wes_pkg::GRID_WIDTH_RESET;
            grid_height_reg <= wes_pkg::GRID_HEIGHT_RESET;
            coef_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wes_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[10:0];
                wes_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data[12:0];
                wes_pkg::REG_COEFFICIENT: coef_reg        <= cfg_data;
                default:                  coef_reg        <= coef_reg;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb
    begin
        if (grid_width_reg < 11'd3)
        begin
            w_eff = (CW+1)'(3);
        end
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (CW+1)'(grid_width_reg);
        end
        if (grid_height_reg < 13'd3)
        begin
            h_eff = (RW+1)'(3);
        end
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = (RW+1)'(grid_height_reg);
        end
    end

    wes_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pressure_now     (pressure_now),
        .pressure_before  (pressure_before),
        .velocity_squared (velocity_squared),
        .restart          (restart),
        .w_eff            (w_eff),
        .h_eff            (h_eff),
        .push             (push),
        .push_data        (push_data),
        .full             (full)
    );

    wes_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    wes_back #(
        .CW    (CW),
        .RW    (RW),
        .JOB_W (JOB_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .pop           (pop),
        .pop_data      (pop_data),
        .coef          (coef_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_column    (out_column),
        .out_row       (out_row),
        .pressure_next (pressure_next),
        .run_last      (run_last)
    );

endmodule

`default_nettype wire

// File: test/wave_equation_stencil_step_tb.sv
// ---------------------------------------------------------------------------
// wave_equation_stencil_step_tb
// Self-checking bench for the streamed 5-point wave equation stencil.
// ---------------------------------------------------------------------------
// Grid points are streamed in raster order over grids of many shapes, mostly small.
// A bit-accurate predictor mirrors the line buffers, the stencil window and
// the frame counters, and queues the expected results for every accepted
// point. The monitor compares each output transaction with the oldest one.
// Sender gaps and receiver stalls change by phase, and one phase holds the
// receiver off long enough to back the block up into its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_equation_stencil_step_tb;

    localparam int  GRID_MAX      = 1024;
    localparam int  ROWS_MAX      = 4096;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  DRAIN_CYCLES  = 60;
    localparam int  RX_HOLD_LEN   = 400;
    localparam int  RANDOM_POINTS = 140;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] p_now;
        logic [31:0] p_old;
        logic [31:0] vel;
    } grid_point_t;

    typedef struct {
        logic [9:0]  col;
        logic [11:0] row;
        logic [31:0] value;
        logic        last;
    } wave_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] pressure_now = '0;
    logic [31:0] pressure_before = '0;
    logic [31:0] velocity_squared = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [9:0] out_column;
    logic [11:0] out_row;
    logic signed [31:0] pressure_next;
    logic run_last;

    wave_equation_stencil_step dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pressure_now(pressure_now), .pressure_before(pressure_before),
        .velocity_squared(velocity_squared),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_column(out_column), .out_row(out_row),
        .pressure_next(pressure_next), .run_last(run_last)
    );

    always #5 clk = ~clk;

    // Predictor state
    logic [10:0] width_reg = wes_pkg::GRID_WIDTH_RESET;
    logic [12:0] height_reg = wes_pkg::GRID_HEIGHT_RESET;
    logic [31:0] coef_reg = '0;
    logic [31:0] line_p [GRID_MAX];
    logic [31:0] line_p2 [GRID_MAX];
    logic [31:0] line_old [GRID_MAX];
    logic [31:0] line_vel [GRID_MAX];
    logic [31:0] west_p = '0;
    logic [31:0] win_n1 = '0, win_n2 = '0, win_nn1 = '0, win_old1 = '0, win_vel1 = '0;
    int col_pos = 0;
    int row_pos = 0;

    grid_point_t  point_q [$];
    wave_result_t result_q [$];

    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic send_hold = 1'b0;
    logic rx_hold_go = 1'b0;
    int rx_hold_cnt = 0;

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // Next pressure at one interior point, rounded and saturated
    function automatic logic [31:0] wave_next(logic [31:0] pc, logic [31:0] pw,
                                              logic [31:0] pe, logic [31:0] pn,
                                              logic [31:0] ps, logic [31:0] pold,
                                              logic [31:0] vel);
        longint lap;
        longint term;
        longint total;
        logic [127:0] prod;
        logic [127:0] mag;
        lap = sx(pw) + sx(pe) + sx(pn) + sx(ps) - 4 * sx(pc);
        mag = 128'(lap < 0 ? -lap : lap);
        prod = {96'b0, vel} * {96'b0, coef_reg};
        prod = (prod * mag + (128'd1 << 39)) >> 40;
        if (prod > (128'd1 << 40))
            prod = 128'd1 << 40;
        term = longint'(prod[40:0]);
        if (lap < 0)
            term = -term;
        total = 2 * sx(pc) - sx(pold) + term;
        if (total > 64'sd2147483647)
            total = 64'sd2147483647;
        if (total < -64'sd2147483648)
            total = -64'sd2147483648;
        return total[31:0];
    endfunction

    // Advance the predictor by one accepted grid point
    task automatic predict_point(grid_point_t pt);
        int w;
        int h;
        int x;
        int z;
        int first;
        logic [31:0] a;
        logic [31:0] val;
        wave_result_t r;
        w = (width_reg < 3) ? 3 : (width_reg > GRID_MAX) ? GRID_MAX : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > ROWS_MAX) ? ROWS_MAX : height_reg;
        x = (col_pos >= w) ? w - 1 : col_pos;
        z = (row_pos >= h) ? h - 1 : row_pos;
        a = line_p[x];
        first = result_q.size();
        if (x >= 1 && z >= 1)
        begin
            if (x - 1 >= 1 && x - 1 <= w - 2 && z - 1 >= 1 && z - 1 <= h - 2)
                val = wave_next(win_n1, win_n2, a, win_nn1, west_p, win_old1, win_vel1);
            else
                val = win_n1;
            r = '{col: 10'(x - 1), row: 12'(z - 1), value: val, last: 1'b0};
            result_q.push_back(r);
        end
        if (x == w - 1 && z >= 1)
        begin
            r = '{col: 10'(x), row: 12'(z - 1), value: a, last: 1'b0};
            result_q.push_back(r);
        end
        if (z == h - 1)
        begin
            r = '{col: 10'(x), row: 12'(z), value: pt.p_now, last: 1'b0};
            result_q.push_back(r);
        end
        if (result_q.size() > first)
            result_q[result_q.size() - 1].last = 1'b1;
        win_n2 = win_n1;
        win_n1 = a;
        win_nn1 = line_p2[x];
        win_old1 = line_old[x];
        win_vel1 = line_vel[x];
        line_p2[x] = a;
        line_p[x] = pt.p_now;
        line_old[x] = pt.p_old;
        line_vel[x] = pt.vel;
        west_p = pt.p_now;
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (z + 1 >= h) ? 0 : z + 1;
        end
        else
        begin
            col_pos = x + 1;
            row_pos = z;
        end
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    // Drive the input channel from the queue of pending points
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_point('{p_now: pressure_now, p_old: pressure_before,
                                vel: velocity_squared});
            if (!in_valid || in_ready)
            begin
                if (point_q.size() > 0 && !send_hold
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    pressure_now <= point_q[0].p_now;
                    pressure_before <= point_q[0].p_old;
                    velocity_squared <= point_q[0].vel;
                    point_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Count the long receiver hold-off
    always @(posedge clk)
    begin
        if (!rx_hold_go)
            rx_hold_cnt <= 0;
        else if (rx_hold_cnt < RX_HOLD_LEN)
            rx_hold_cnt <= rx_hold_cnt + 1;
    end

    // Check output transactions and pick the next ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                    report_mismatch($sformatf("unexpected result (%0d,%0d)",
                                              out_column, out_row));
                else
                begin
                    if (out_column !== result_q[0].col || out_row !== result_q[0].row
                        || pressure_next !== result_q[0].value
                        || run_last !== result_q[0].last)
                        report_mismatch($sformatf(
                            "got (%0d,%0d) %h last %b, want (%0d,%0d) %h last %b",
                            out_column, out_row, pressure_next, run_last,
                            result_q[0].col, result_q[0].row, result_q[0].value,
                            result_q[0].last));
                    result_q.pop_front();
                end
            end
            out_ready <= !(rx_hold_go && rx_hold_cnt < RX_HOLD_LEN)
                         && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("wave_equation_stencil_step: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        unique case (idx)
            wes_pkg::REG_GRID_WIDTH:
            begin
                width_reg = data[10:0];
                col_pos = 0;
                row_pos = 0;
            end
            wes_pkg::REG_GRID_HEIGHT:
            begin
                height_reg = data[12:0];
                col_pos = 0;
                row_pos = 0;
            end
            wes_pkg::REG_COEFFICIENT: coef_reg = data;
            default: ;
        endcase
    endtask

    // Wait until every point is taken and every result has arrived
    task automatic drain_all();
        while (point_q.size() > 0 || in_valid || result_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        unique case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_velocity();
        unique case ($urandom_range(3))
            0: return $urandom;
            1: return 32'hffff_ffff;
            default: return $urandom_range(1 << 12);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        unique case ($urandom_range(4))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return $urandom_range(1 << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_points(int n);
        repeat (n)
            point_q.push_back('{p_now: rand_sample(), p_old: rand_sample(),
                                vel: rand_velocity()});
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    initial
    begin
        int sent;
        int phase;
        int w;
        int h;
        int n;
        for (int i = 0; i < GRID_MAX; i++)
        begin
            line_p[i] = '0;
            line_p2[i] = '0;
            line_old[i] = '0;
            line_vel[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: 3x3 grid with extreme samples and full coefficient
        write_reg(wes_pkg::REG_GRID_WIDTH, 32'd3);
        write_reg(wes_pkg::REG_GRID_HEIGHT, 32'd3);
        write_reg(wes_pkg::REG_COEFFICIENT, 32'hffff_ffff);
        point_q.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff});
        point_q.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h0});
        point_q.push_back('{32'h0, 32'hffff_ffff, 32'h1});
        point_q.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
        point_q.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff});
        point_q.push_back('{32'h8000_0000, 32'h0, 32'h7fff_ffff});
        point_q.push_back('{32'h0, 32'h1, 32'h0});
        point_q.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff});
        point_q.push_back('{32'h1, 32'hffff_ffff, 32'h100});
        // wrap into a second frame of the same geometry
        queue_points(9);
        drain_all();

        // Geometry below range clamps to 3x3; unused index does nothing
        write_reg(wes_pkg::REG_GRID_WIDTH, 32'hffff_f800);
        write_reg(wes_pkg::REG_GRID_HEIGHT, 32'hffff_e001);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        write_reg(wes_pkg::REG_COEFFICIENT, 32'h0000_0001);
        queue_points(9);
        drain_all();

        // Largest geometry and above-range values: a partial first row only
        write_reg(wes_pkg::REG_GRID_WIDTH, 32'd1024);
        write_reg(wes_pkg::REG_GRID_HEIGHT, 32'd4096);
        write_reg(wes_pkg::REG_GRID_WIDTH, 32'h7ff);
        write_reg(wes_pkg::REG_GRID_HEIGHT, 32'h1fff);
        queue_points(5);
        drain_all();

        // Random grids, rotating the idling pattern each phase
        sent = 0;
        phase = 0;
        while (sent < RANDOM_POINTS || phase < 3)
        begin
            unique case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(47, 0);
                2: set_idling(0, 47);
                default: set_idling(15, 15);
            endcase
            w = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 3);
            h = $urandom_range(5, 3);
            n = w * h * $urandom_range(2, 1);
            // a few frames are cut short by the next geometry write
            if (phase != 1 && $urandom_range(4) == 0)
                n = $urandom_range(w * h - 1, 1);
            write_reg(wes_pkg::REG_GRID_WIDTH, 32'(w));
            write_reg(wes_pkg::REG_GRID_HEIGHT, 32'(h));
            write_reg(wes_pkg::REG_COEFFICIENT, rand_coef());
            if (phase == 1)
            begin
                // back the block up into its input
                @(posedge clk);
                rx_hold_go <= 1'b1;
                queue_points(n);
                while (rx_hold_cnt < RX_HOLD_LEN)
                    @(posedge clk);
                @(posedge clk);
                rx_hold_go <= 1'b0;
            end
            else if (phase == 2)
            begin
                // pause the sender midway until the block runs dry
                queue_points(n / 2);
                while (point_q.size() > 0 || in_valid)
                    @(posedge clk);
                @(posedge clk);
                send_hold <= 1'b1;
                while (result_q.size() > 0)
                    @(posedge clk);
                @(posedge clk);
                send_hold <= 1'b0;
                queue_points(n - n / 2);
            end
            else
            begin
                queue_points(n);
            end
            drain_all();
            sent += n;
            phase++;
        end

        if (fail_count == 0)
            $display("wave_equation_stencil_step: match");
        else
            $display("wave_equation_stencil_step: mismatch");
        $finish;
    end

endmodule
